// File: src/nalsp_pkg.sv
// ----------------------------------------------------------------------------
// NAL splitter package
// Shared types and constants for the Annex B NAL unit splitter.
// ----------------------------------------------------------------------------
`default_nettype none

package nalsp_pkg;

  // Field widths
  localparam int BYTE_W  = 8;
  localparam int POS_W   = 32;
  localparam int LEN_W   = 20;
  localparam int STAT_W  = 2;
  localparam int PHASE_W = 2;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 64;

  // Length register reset value and saturation mark
  localparam logic [LEN_W-1:0] MAX_LEN_RST = 20'd100000;
  localparam logic [LEN_W-1:0] LEN_SAT     = 20'hFFFFF;

  // Record status codes
  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOSTART = 2'd1;
  localparam logic [STAT_W-1:0] ST_SAT     = 2'd2;

  // Header field masks
  localparam logic [BYTE_W-1:0] HDR_FZ_MASK   = 8'h80;
  localparam logic [BYTE_W-1:0] HDR_REF_MASK  = 8'h60;
  localparam logic [BYTE_W-1:0] HDR_TYPE_MASK = 8'h1f;

  // One incoming stream byte
  typedef struct packed {
    logic [BYTE_W-1:0] byte_value;
    logic              end_of_stream;
  } item_t;

  // One unit record, as sent out
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [4:0]        unit_type;
    logic [1:0]        ref_idc;
    logic              forbidden_zero;
    logic [LEN_W-1:0]  payload_length;
    logic              prefix_four;
    logic [POS_W-1:0]  unit_offset;
  } rec_t;

endpackage

`default_nettype wire

// File: src/nalsp_in_stage.sv
// ----------------------------------------------------------------------------
// NAL splitter input stage
// Registers one incoming stream item and holds it until the core takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module nalsp_in_stage
  import nalsp_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire item_t in_item,
  output logic       item_valid,
  output item_t      item,
  input  wire logic  item_done
);

  logic  valid_r, valid_nxt;
  item_t item_r;

  // Free when empty or when the held item leaves this cycle
  assign in_ready = !valid_r || item_done;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (item_done) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

`default_nettype wire

// File: src/nalsp_core.sv
// ----------------------------------------------------------------------------
// NAL splitter core
// Start code match, scan state, unit records; one byte/cycle unless stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module nalsp_core
  import nalsp_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_wr_en,
  input  wire logic [LEN_W-1:0] cfg_wr_data,
  input  wire logic             item_valid,
  input  wire item_t            item,
  input  wire logic             out_free,
  output logic                  item_done,
  output logic                  rec_load,
  output rec_t                  rec
);

  localparam logic [PHASE_W-1:0] PH_AWAIT = 2'd0;
  localparam logic [PHASE_W-1:0] PH_HUNT  = 2'd1;
  localparam logic [PHASE_W-1:0] PH_UNIT  = 2'd2;

  localparam logic [LEN_W-1:0] LEN_ONE   = 20'd1;
  localparam logic [LEN_W-1:0] PFX3_LEN  = 20'd3;
  localparam logic [LEN_W-1:0] PFX4_LEN  = 20'd4;
  localparam logic [POS_W-1:0] PFX3_BACK = 32'd2;
  localparam logic [POS_W-1:0] PFX4_BACK = 32'd3;
  localparam logic [POS_W-1:0] POS_TWO   = 32'd2;
  localparam logic [POS_W-1:0] POS_THREE = 32'd3;

  logic [LEN_W-1:0]   max_len_r;
  logic [23:0]        recent_r, recent_nxt;
  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [POS_W-1:0]   start_r, start_nxt;
  logic [LEN_W-1:0]   count_r, count_nxt;
  logic [BYTE_W-1:0]  hdr_r, hdr_nxt;
  logic               pf4_r, pf4_nxt;

  logic [BYTE_W-1:0]  b;
  logic               eos;
  logic               four, three, code_end;
  logic [LEN_W-1:0]   count_inc, raw;
  logic [BYTE_W-1:0]  hdr_eff, hdr_out;
  logic [BYTE_W-1:0]  fz_bits, ref_bits, type_bits;
  logic               sat;
  logic               has_rec;
  logic               do_open, open_four;
  rec_t               rec_c;

  // Length register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_LEN_RST;
    end else if (cfg_wr_en) begin
      max_len_r <= cfg_wr_data;
    end
  end

  // Start code match on the last three bytes plus this one
  assign b        = item.byte_value;
  assign eos      = item.end_of_stream;
  assign four     = (recent_r == 24'd0) && (b == 8'd1);
  assign three    = (recent_r[15:0] == 16'd0) && (b == 8'd1);
  assign code_end = four || three;

  // Payload count and header capture for an open unit
  assign count_inc = (count_r != LEN_SAT) ? count_r + LEN_ONE : count_r;
  assign hdr_eff   = (count_inc == LEN_ONE) ? b : hdr_r;
  assign raw       = four  ? count_inc - PFX4_LEN :
                     three ? count_inc - PFX3_LEN : count_inc;
  assign sat       = (count_inc == LEN_SAT) || (raw > max_len_r);
  assign hdr_out   = ((raw == '0) && !sat) ? '0 : hdr_eff;
  assign fz_bits   = (hdr_out & HDR_FZ_MASK) >> 7;
  assign ref_bits  = (hdr_out & HDR_REF_MASK) >> 5;
  assign type_bits = hdr_out & HDR_TYPE_MASK;

  // Scan decisions, record and next state
  always_comb begin
    has_rec    = 1'b0;
    do_open    = 1'b0;
    open_four  = 1'b0;
    phase_nxt  = phase_r;
    count_nxt  = count_r;
    hdr_nxt    = hdr_r;
    recent_nxt = {recent_r[15:0], b};
    pos_nxt    = pos_r + 32'd1;
    start_nxt  = start_r;
    pf4_nxt    = pf4_r;
    rec_c      = '0;
    unique case (phase_r)
      PH_AWAIT: begin
        if ((pos_r == POS_TWO) && three) begin
          do_open = 1'b1;
        end else if (pos_r == POS_THREE) begin
          if (four) begin
            do_open   = 1'b1;
            open_four = 1'b1;
          end else begin
            has_rec      = 1'b1;
            rec_c.status = ST_NOSTART;
            if (three) begin
              do_open = 1'b1;
            end else begin
              phase_nxt = PH_HUNT;
            end
          end
        end
      end
      PH_HUNT: begin
        do_open   = code_end;
        open_four = four;
      end
      PH_UNIT: begin
        count_nxt = count_inc;
        hdr_nxt   = hdr_eff;
        if (code_end || eos) begin
          has_rec              = 1'b1;
          rec_c.unit_offset    = start_r;
          rec_c.prefix_four    = pf4_r;
          rec_c.payload_length = sat ? max_len_r : raw;
          rec_c.forbidden_zero = fz_bits[0];
          rec_c.ref_idc        = ref_bits[1:0];
          rec_c.unit_type      = type_bits[4:0];
          rec_c.status         = sat ? ST_SAT : ST_OK;
        end
        do_open   = code_end;
        open_four = four;
      end
      default: begin
        phase_nxt = PH_AWAIT;
      end
    endcase

    // Next state: open a unit, then end of stream clears everything
    if (do_open) begin
      phase_nxt = PH_UNIT;
      start_nxt = pos_r - (open_four ? PFX4_BACK : PFX3_BACK);
      pf4_nxt   = open_four;
      count_nxt = '0;
      hdr_nxt   = '0;
    end
    if (eos) begin
      recent_nxt = '1;
      phase_nxt  = PH_AWAIT;
      pos_nxt    = '0;
      start_nxt  = '0;
      count_nxt  = '0;
      hdr_nxt    = '0;
      pf4_nxt    = 1'b0;
    end
  end

  // Item leaves when it makes no record or the output register is free
  assign item_done = item_valid && (!has_rec || out_free);
  assign rec_load  = item_done && has_rec;
  assign rec       = rec_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      recent_r <= '1;
      phase_r  <= PH_AWAIT;
      pos_r    <= '0;
      start_r  <= '0;
      count_r  <= '0;
      hdr_r    <= '0;
      pf4_r    <= 1'b0;
    end else if (item_done) begin
      recent_r <= recent_nxt;
      phase_r  <= phase_nxt;
      pos_r    <= pos_nxt;
      start_r  <= start_nxt;
      count_r  <= count_nxt;
      hdr_r    <= hdr_nxt;
      pf4_r    <= pf4_nxt;
    end
  end

endmodule

`default_nettype wire

// File: src/nalsp_out_stage.sv
// ----------------------------------------------------------------------------
// NAL splitter output stage
// Holds one unit record until the downstream side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module nalsp_out_stage
  import nalsp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic rec_load,
  input  wire rec_t rec,
  output logic      out_free,
  output logic      out_valid,
  input  wire logic out_ready,
  output rec_t      out_rec
);

  logic valid_r, valid_nxt;
  rec_t rec_r;

  assign out_free = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (rec_load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (rec_load) begin
      rec_r <= rec;
    end
  end

  assign out_valid = valid_r;
  assign out_rec   = rec_r;

endmodule

`default_nettype wire

// File: src/annexb_nal_unit_splitter_unit.sv
// ----------------------------------------------------------------------------
// Annex B NAL unit splitter
// Finds start codes in an Annex B byte stream and sends one record per unit.
// ----------------------------------------------------------------------------
//  channel | dir | handshake        | contents
//  in_     | in  | tvalid/tready    | tdata[7:0] byte_value, tlast end_of_stream
//  out_    | out | tvalid/tready    | tdata: unit record (see port list)
//  cfg_    | in  | wr_en            | wr_data: max_len
//
//  One byte per cycle unless a record waits on a stalled output: input
//  register, combinational match and record logic, output register. A record
//  shows on out_tvalid from the output register after its closing byte leaves the input register.
//  A stalled output only holds the input when the held byte makes a record.
//  Reset is synchronous, active low, and sets max_len to 100000.
// ----------------------------------------------------------------------------
`default_nettype none

module annexb_nal_unit_splitter_unit
  import nalsp_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // in_tdata: [7:0] byte_value
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  input  wire logic                  in_tlast,   // end_of_stream
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // out_tdata: [31:0] unit_offset, [32] prefix_four, [52:33] payload_length,
  // [53] forbidden_zero, [55:54] ref_idc, [60:56] unit_type, [62:61] status,
  // [63] zero
  output logic [OUT_DATA_W-1:0]      out_tdata,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  input  wire logic                  cfg_wr_en,
  input  wire logic [LEN_W-1:0]      cfg_wr_data
);

  item_t in_item, item;
  logic  item_valid, item_done;
  logic  rec_load, out_free;
  rec_t  rec, out_rec;

  assign in_item.byte_value    = in_tdata;
  assign in_item.end_of_stream = in_tlast;

  nalsp_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_item    (in_item),
    .item_valid (item_valid),
    .item       (item),
    .item_done  (item_done)
  );

  nalsp_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .item_valid  (item_valid),
    .item        (item),
    .out_free    (out_free),
    .item_done   (item_done),
    .rec_load    (rec_load),
    .rec         (rec)
  );

  nalsp_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .rec_load  (rec_load),
    .rec       (rec),
    .out_free  (out_free),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_rec   (out_rec)
  );

  // Record fields packed from bit 0 up, top bit zero
  assign out_tdata = {1'b0, out_rec};

endmodule

`default_nettype wire

// File: src/nalsp_checker.sv
// ----------------------------------------------------------------------------
// NAL splitter port checker
// Watches the splitter's ports and flags broken records or handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module nalsp_checker
  import nalsp_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic [OUT_DATA_W-1:0] out_tdata,
  input wire logic                  out_tvalid,
  input wire logic                  out_tready
);

  // A record waiting for the sink stays up
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("out item dropped while stalled");

  // A stalled record keeps its bits
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("out item changed while stalled");

  // No record straight out of reset
  a_reset_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_tvalid)
    else $error("out item right after reset");

  // Status is one of the three defined codes
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[62:61] == ST_OK) || (out_tdata[62:61] == ST_NOSTART)
                   || (out_tdata[62:61] == ST_SAT))
    else $error("undefined status code");

  // A missing opening start code gives an all-zero record
  a_nostart_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[62:61] == ST_NOSTART) |-> (out_tdata[60:0] == '0))
    else $error("no-start record carries data");

endmodule

bind annexb_nal_unit_splitter_unit nalsp_checker u_nalsp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tdata  (out_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);

`default_nettype wire
